>>> src/irlin_pkg.sv
// Shared types, constants and tables of the IR range filter and linearizer.
`default_nettype none
package irlin_pkg;

	localparam int SAMPLE_W       = 10;
	localparam int AVG_W          = 10;
	localparam int DIST_W         = 14;
	localparam int OFF_W          = 12;
	localparam int D16_W          = 12;
	localparam int CNT_W          = 5;
	localparam int MUL_W          = 32;
	localparam int WINDOW_LEN_DEF = 8;

	localparam logic REG_CURVE  = 1'b0;
	localparam logic REG_OFFSET = 1'b1;

	localparam logic signed [OFF_W-1:0] OFF_MIN = -12'sd1024;
	localparam logic signed [OFF_W-1:0] OFF_MAX = 12'sd1024;

	localparam logic [20:0] CURVE_BASE [2] = '{21'd1200466, 21'd1223593};
	localparam logic [16:0] CURVE_POW  [2] = '{17'd75366, 17'd72090};
	localparam logic [D16_W-1:0] CURVE_LO16 [2] = '{12'd160, 12'd320};
	localparam logic [D16_W-1:0] CURVE_HI16 [2] = '{12'd1280, 12'd4000};

	typedef logic [30:0] exp_tbl_t [16];

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIVI,
		ST_DIV,
		ST_LOGI,
		ST_SQM,
		ST_SQR,
		ST_YM,
		ST_YR,
		ST_EXP,
		ST_EXR,
		ST_SHF,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic upd_en;
	} ring_ctrl_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bit_v;
		logic [63:0] xv;
		res   = '0;
		bit_v = 64'd1 << 62;
		xv    = x;
		for (int i = 0; i < 32; i++) begin
			if (xv >= res + bit_v) begin
				xv  = xv - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	function automatic exp_tbl_t exp2_tbl();
		exp_tbl_t t;
		logic [63:0] r;
		r = 64'd2 << 30;
		for (int k = 0; k < 16; k++) begin
			r    = isqrt64(r << 30);
			t[k] = r[30:0];
		end
		return t;
	endfunction

	localparam exp_tbl_t EXP2_TBL = exp2_tbl();

endpackage
`default_nettype wire

>>> src/irlin_mul.sv
// Shared 32x32 multiplier with registered product.
`default_nettype none
module irlin_mul (
	input  wire logic                           clk,
	input  wire logic [irlin_pkg::MUL_W-1:0]    a,
	input  wire logic [irlin_pkg::MUL_W-1:0]    b,
	output logic      [2*irlin_pkg::MUL_W-1:0]  p
);
	import irlin_pkg::*;

	logic [2*MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule
`default_nettype wire

>>> src/irlin_ring.sv
// Sample ring memory with valid bits and running window sum.
`default_nettype none
module irlin_ring #(
	parameter int WINDOW_LEN = irlin_pkg::WINDOW_LEN_DEF
) (
	input  wire logic                                                clk,
	input  wire logic                                                arst_n,
	input  wire irlin_pkg::ring_ctrl_t                               ctrl,
	input  wire logic [irlin_pkg::SAMPLE_W-1:0]                      sample,
	output logic      [irlin_pkg::SAMPLE_W+$clog2(WINDOW_LEN)-1:0]   sum
);
	import irlin_pkg::*;

	localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
	localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

	logic [SAMPLE_W-1:0]   mem [WINDOW_LEN];
	logic [WINDOW_LEN-1:0] vld_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [SAMPLE_W-1:0]   rd_s1;
	logic                  rd_vld_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SAMPLE_W-1:0]   old;

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_s1 <= mem[slot_q];
		end
		if (ctrl.upd_en) begin
			mem[slot_q] <= sample;
		end
	end

	assign old = rd_vld_q ? rd_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			slot_q   <= '0;
			rd_vld_q <= 1'b0;
			sum_q    <= '0;
		end else begin
			if (ctrl.rd_en) begin
				rd_vld_q <= vld_q[slot_q];
			end
			if (ctrl.upd_en) begin
				vld_q[slot_q] <= 1'b1;
				sum_q         <= sum_q - SUM_W'(old) + SUM_W'(sample);
				if (slot_q == SLOT_W'(WINDOW_LEN - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	assign sum = sum_q;

endmodule
`default_nettype wire

>>> src/ir_range_filter_linearizer.sv
// Top level: window averager and power-law distance linearizer.
//
// channel   | signals                                      | dir
// sample    | sample_valid, sample_ready, adc_sample       | in
// result    | result_valid, result_ready, averaged_sample, | out
//           | distance                                     |
// config    | psel, penable, pwrite, paddr, pwdata, prdata | in/out
//
// From accept to the next accept of a beat with a nonzero mean, the sequence is:
// the shared multiplier does one reciprocal product for the mean, 16 squarings and
// the scaling product, then 16 exp2 steps, where each step on a set fraction bit
// adds one more product.
// A zero mean skips the conversion. Reset clears the ring valid
// bits, the sum, the config and the sequencer. sample_ready is high only in idle; a
// finished result waits in the output register while the next beat is taken, and
// the sequencer holds in its last state for every cycle that register stays full.
`default_nettype none
module ir_range_filter_linearizer #(
	parameter int WINDOW_LEN = irlin_pkg::WINDOW_LEN_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                sample_valid,
	output logic                                     sample_ready,
	input  wire logic [irlin_pkg::SAMPLE_W-1:0]      adc_sample,
	output logic                                     result_valid,
	input  wire logic                                result_ready,
	output logic      [irlin_pkg::AVG_W-1:0]         averaged_sample,
	output logic signed [irlin_pkg::DIST_W-1:0]      distance,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [2:0]                          paddr,
	input  wire logic [31:0]                         pwdata,
	output logic      [31:0]                         prdata,
	output logic                                     pready
);
	import irlin_pkg::*;

	localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
	localparam int DIV_SH = SUM_W + $clog2(WINDOW_LEN);
	localparam logic [MUL_W-1:0] DIV_M = MUL_W'(((longint'(1) << DIV_SH) +
		longint'(WINDOW_LEN) - longint'(1)) / longint'(WINDOW_LEN));

	state_t state_q, state_d;

	logic [CNT_W-1:0]    cnt_q;
	logic                curve_q;
	logic [OFF_W-1:0]    calib_q;
	logic                out_vld_q;
	logic [AVG_W-1:0]    avg_out_q;
	logic [DIST_W-1:0]   dist_out_q;

	logic [SAMPLE_W-1:0] sample_q;
	logic [SUM_W-1:0]    quo_q;
	logic [3:0]          e_q;
	logic [30:0]         m_q;
	logic [15:0]         frac_q;
	logic [20:0]         y_q;
	logic [30:0]         acc_q;
	logic [D16_W-1:0]    d16_q;

	ring_ctrl_t          ring_ctrl;
	logic [SUM_W-1:0]    sum;
	logic [MUL_W-1:0]    mul_a;
	logic [MUL_W-1:0]    mul_b;
	logic [2*MUL_W-1:0]  mul_p;

	logic                cfg_wr;
	logic                accept;
	logic                out_load;
	logic [AVG_W-1:0]    avg;
	logic [3:0]          e_find;
	logic [31:0]         mm;
	logic [21:0]         y_pl;
	logic [15:0]         y_frac;
	logic [3:0]          y_idx;
	logic                y_bit;
	logic [5:0]          ip;
	logic [63:0]         shv;
	logic [33:0]         q8;
	logic [33:0]         q8c;
	logic [33:0]         hi8;
	logic [33:0]         lo8;
	logic [33:0]         q8r;
	logic [DIST_W-1:0]   off_sat;
	logic [DIST_W-1:0]   dist_d;

	irlin_ring #(.WINDOW_LEN(WINDOW_LEN)) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ring_ctrl),
		.sample (sample_q),
		.sum    (sum)
	);

	irlin_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign accept   = sample_valid && sample_ready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_load = (state_q == ST_FIN) && (!out_vld_q || result_ready);

	assign avg    = quo_q[AVG_W-1:0];
	assign mm     = mul_p[61:30];
	assign y_pl   = 22'(mul_p[35:16]);
	assign y_frac = y_q[15:0];
	assign y_idx  = 4'd15 - cnt_q[3:0];
	assign y_bit  = y_frac[y_idx];

	always_comb begin
		e_find = '0;
		for (int i = 0; i < AVG_W; i++) begin
			if (avg[i]) begin
				e_find = 4'(i);
			end
		end
	end

	always_comb begin
		ip = {1'b0, y_q[20:16]} + 6'd8;
		if (ip > 6'd32) begin
			ip = 6'd32;
		end
		shv = {33'b0, acc_q} << ip;
		q8  = shv[63:30];
		hi8 = {14'b0, CURVE_HI16[curve_q], 8'b0};
		lo8 = {14'b0, CURVE_LO16[curve_q], 8'b0};
		q8c = q8;
		if (q8c > hi8) begin
			q8c = hi8;
		end
		if (q8c < lo8) begin
			q8c = lo8;
		end
		q8r = q8c + 34'd128;
	end

	always_comb begin
		if ($signed(calib_q) < OFF_MIN) begin
			off_sat = DIST_W'(OFF_MIN);
		end else if ($signed(calib_q) > OFF_MAX) begin
			off_sat = DIST_W'(OFF_MAX);
		end else begin
			off_sat = {{(DIST_W-OFF_W){calib_q[OFF_W-1]}}, calib_q};
		end
		dist_d = DIST_W'(d16_q) + off_sat;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD:  state_d = ST_DIVI;
			ST_DIVI: state_d = ST_DIV;
			ST_DIV:  state_d = ST_LOGI;
			ST_LOGI: state_d = (avg == '0) ? ST_FIN : ST_SQM;
			ST_SQM:  state_d = ST_SQR;
			ST_SQR:  state_d = (cnt_q == CNT_W'(15)) ? ST_YM : ST_SQM;
			ST_YM:   state_d = ST_YR;
			ST_YR:   state_d = ST_EXP;
			ST_EXP: begin
				if (y_bit) begin
					state_d = ST_EXR;
				end else if (cnt_q == CNT_W'(15)) begin
					state_d = ST_SHF;
				end
			end
			ST_EXR:  state_d = (cnt_q == CNT_W'(15)) ? ST_SHF : ST_EXP;
			ST_SHF:  state_d = ST_FIN;
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_ready     = (state_q == ST_IDLE);
		ring_ctrl.rd_en  = accept;
		ring_ctrl.upd_en = (state_q == ST_UPD);
		mul_a            = {1'b0, m_q};
		mul_b            = {1'b0, m_q};
		unique case (state_q)
			ST_DIVI: begin
				mul_a = MUL_W'(sum);
				mul_b = DIV_M;
			end
			ST_YM: begin
				mul_a = MUL_W'(CURVE_POW[curve_q]);
				mul_b = MUL_W'({e_q, frac_q});
			end
			ST_EXP: begin
				mul_a = {1'b0, acc_q};
				mul_b = {1'b0, EXP2_TBL[cnt_q[3:0]]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			curve_q   <= 1'b0;
			calib_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_CURVE:  curve_q <= pwdata[0];
					REG_OFFSET: calib_q <= pwdata[OFF_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_DIVI, ST_LOGI, ST_YR: cnt_q <= '0;
				ST_SQR, ST_EXR:          cnt_q <= cnt_q + 1'b1;
				ST_EXP: begin
					if (!y_bit) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= adc_sample;
		end
		if (out_load) begin
			avg_out_q  <= avg;
			dist_out_q <= dist_d;
		end
		unique case (state_q)
			ST_DIV: quo_q <= mul_p[DIV_SH +: SUM_W];
			ST_LOGI: begin
				e_q    <= e_find;
				m_q    <= 31'(avg) << (5'd30 - 5'(e_find));
				frac_q <= '0;
				d16_q  <= CURVE_HI16[curve_q];
			end
			ST_SQR: begin
				m_q    <= mm[31] ? mm[31:1] : mm[30:0];
				frac_q <= {frac_q[14:0], mm[31]};
			end
			ST_YR: begin
				y_q   <= (y_pl > 22'(CURVE_BASE[curve_q])) ? '0 :
					21'(22'(CURVE_BASE[curve_q]) - y_pl);
				acc_q <= {1'b1, 30'b0};
			end
			ST_EXR: acc_q <= mul_p[60:30];
			ST_SHF: d16_q <= q8r[8+D16_W-1:8];
			default: begin
			end
		endcase
	end

	always_comb begin
		unique case (paddr[2])
			REG_OFFSET: prdata = {{(32-OFF_W){calib_q[OFF_W-1]}}, calib_q};
			default:    prdata = {31'b0, curve_q};
		endcase
	end

	assign pready          = 1'b1;
	assign result_valid    = out_vld_q;
	assign averaged_sample = avg_out_q;
	assign distance        = dist_out_q;

endmodule
`default_nettype wire

>>> src/irlin_chk.sv
// Port-level checker of the linearizer and its bind.
`default_nettype none
module irlin_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           sample_valid,
	input wire logic                           sample_ready,
	input wire logic                           result_valid,
	input wire logic                           result_ready,
	input wire logic [irlin_pkg::AVG_W-1:0]    averaged_sample,
	input wire logic [irlin_pkg::DIST_W-1:0]   distance,
	input wire logic                           pready
);
	import irlin_pkg::*;

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample_ready high right after an accepted beat");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(distance) && $stable(averaged_sample))
		else $error("stalled result changed");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($signed(distance) >= -14'sd864) && ($signed(distance) <= 14'sd5024))
		else $error("distance out of range");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind ir_range_filter_linearizer irlin_chk u_irlin_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.sample_valid    (sample_valid),
	.sample_ready    (sample_ready),
	.result_valid    (result_valid),
	.result_ready    (result_ready),
	.averaged_sample (averaged_sample),
	.distance        (distance),
	.pready          (pready)
);
`default_nettype wire
